[rtl/core/half_sort_and_merge_sorter_macros.svh]
// ----------------------------------------------------------------------------
// half_sort_and_merge_sorter_macros
// assertion macros used by the sorter controller, clocked on i_clk, reset i_rst_n
// ----------------------------------------------------------------------------
`ifndef HALF_SORT_AND_MERGE_SORTER_MACROS_SVH
`define HALF_SORT_AND_MERGE_SORTER_MACROS_SVH

// same-cycle implication
`define HSMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hsms_pkg.sv]
// ----------------------------------------------------------------------------
// hsms_pkg
// types and constants of the half sort and merge sorter
// ----------------------------------------------------------------------------
package hsms_pkg;

    localparam int DATA_WIDTH = 32;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_res;
        logic                         last_res;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_emit;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_KEY_RD,
        S_SORT_KEY,
        S_SORT_CMP_RD,
        S_SORT_CMP,
        S_MRG_START,
        S_MRG_A,
        S_MRG_B,
        S_MRG_OUT
    } t_state;

endpackage

[rtl/core/hsms_ram.sv]
// ----------------------------------------------------------------------------
// hsms_ram
// element store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module hsms_ram
    import hsms_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/hsms_ctrl.sv]
// ----------------------------------------------------------------------------
// hsms_ctrl
// load, insertion sort of both halves and two-way merge over the element store
// ----------------------------------------------------------------------------
`include "half_sort_and_merge_sorter_macros.svh"

module hsms_ctrl
    import hsms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in                   i_item,
    output logic                  o_busy,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output logic [DATA_WIDTH-1:0] o_mem_wdata,
    output logic [AW-1:0]         o_mem_raddr,
    input  logic [DATA_WIDTH-1:0] i_mem_rdata,
    output t_emit                 o_emit
);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic          r_part, n_part;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [CW-1:0] r_k, n_k;
    logic          r_init, n_init;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [DATA_WIDTH-1:0] r_ha, n_ha;
    logic [DATA_WIDTH-1:0] r_hb, n_hb;

    logic [CW-1:0] w_mid, w_lo, w_hi, w_cnt_inc, w_jm1, w_i1, w_a1, w_b1, w_k1;
    logic          w_accept, w_end, w_gt, w_take_a, w_final;

    assign w_mid     = r_n >> 1;
    assign w_lo      = r_part ? w_mid : '0;
    assign w_hi      = r_part ? r_n : w_mid;
    assign w_cnt_inc = r_count + CW'(1);
    assign w_jm1     = r_j - CW'(1);
    assign w_i1      = r_i + CW'(1);
    assign w_a1      = r_a + CW'(1);
    assign w_b1      = r_b + CW'(1);
    assign w_k1      = r_k + CW'(1);
    assign w_accept  = i_start && (r_state == S_LOAD);
    assign w_end     = i_item.last || (w_cnt_inc == CW'(MAX_ELEMENTS));
    assign w_gt      = $signed(i_mem_rdata) > $signed(r_key);
    assign w_take_a  = (r_a < w_mid) && ((r_b >= r_n) || ($signed(r_ha) < $signed(r_hb)));
    assign w_final   = (w_k1 == r_n);
    assign o_busy    = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept && w_end) n_state = S_SORT_KEY_RD;
            end
            S_SORT_KEY_RD: begin
                if (r_i >= w_hi) begin
                    if (r_part) n_state = S_MRG_START;
                end else begin
                    n_state = S_SORT_KEY;
                end
            end
            S_SORT_KEY: n_state = S_SORT_CMP_RD;
            S_SORT_CMP_RD: begin
                n_state = (r_j == w_lo) ? S_SORT_KEY_RD : S_SORT_CMP;
            end
            S_SORT_CMP: begin
                n_state = w_gt ? S_SORT_CMP_RD : S_SORT_KEY_RD;
            end
            S_MRG_START: n_state = S_MRG_A;
            S_MRG_A: n_state = r_init ? S_MRG_B : S_MRG_OUT;
            S_MRG_B: n_state = S_MRG_OUT;
            S_MRG_OUT: begin
                if (w_final) n_state = S_LOAD;
                else n_state = w_take_a ? S_MRG_A : S_MRG_B;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_n         = r_n;
        n_part      = r_part;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_init      = r_init;
        n_key       = r_key;
        n_ha        = r_ha;
        n_hb        = r_hb;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;
        o_emit      = '0;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_count[AW-1:0];
                    o_mem_wdata = i_item.value;
                    if (w_end) begin
                        n_count = '0;
                        n_n     = w_cnt_inc;
                        n_part  = 1'b0;
                        n_i     = CW'(1);
                    end else begin
                        n_count = w_cnt_inc;
                    end
                end
            end
            S_SORT_KEY_RD: begin
                if (r_i >= w_hi) begin
                    if (!r_part) begin
                        n_part = 1'b1;
                        n_i    = w_mid + CW'(1);
                    end else begin
                        n_a    = '0;
                        n_b    = w_mid;
                        n_k    = '0;
                        n_init = 1'b1;
                    end
                end else begin
                    o_mem_raddr = r_i[AW-1:0];
                end
            end
            S_SORT_KEY: begin
                n_key = i_mem_rdata;
                n_j   = r_i;
            end
            S_SORT_CMP_RD: begin
                if (r_j == w_lo) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_j[AW-1:0];
                    o_mem_wdata = r_key;
                    n_i         = w_i1;
                end else begin
                    o_mem_raddr = w_jm1[AW-1:0];
                end
            end
            S_SORT_CMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[AW-1:0];
                if (w_gt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_j         = w_jm1;
                end else begin
                    o_mem_wdata = r_key;
                    n_i         = w_i1;
                end
            end
            S_MRG_START: begin
                o_mem_raddr = r_a[AW-1:0];
            end
            S_MRG_A: begin
                n_ha = i_mem_rdata;
                if (r_init) begin
                    n_init      = 1'b0;
                    o_mem_raddr = r_b[AW-1:0];
                end
            end
            S_MRG_B: begin
                n_hb = i_mem_rdata;
            end
            S_MRG_OUT: begin
                o_emit.valid         = 1'b1;
                o_emit.data.last_res = w_final;
                n_k                  = w_k1;
                if (w_take_a) begin
                    o_emit.data.value_res = r_ha;
                    n_a                   = w_a1;
                    o_mem_raddr           = w_a1[AW-1:0];
                end else begin
                    o_emit.data.value_res = r_hb;
                    n_b                   = w_b1;
                    o_mem_raddr           = w_b1[AW-1:0];
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_n     <= '0;
            r_part  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_k     <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_part  <= n_part;
            r_i     <= n_i;
            r_j     <= n_j;
            r_a     <= n_a;
            r_b     <= n_b;
            r_k     <= n_k;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_ha  <= n_ha;
        r_hb  <= n_hb;
    end

    `HSMS_ASSERT_IMP(a_out_in_range, r_state == S_MRG_OUT, r_k < r_n, "merge index past count")
    `HSMS_ASSERT_NXT(a_last_ends, o_emit.valid && o_emit.data.last_res, r_state == S_LOAD, "no return to load after final result")
    `HSMS_ASSERT_IMP(a_sort_idx, r_state == S_SORT_KEY_RD, r_i <= r_n, "sort index past count")
    `HSMS_ASSERT_IMP(a_merge_ptrs, (r_state == S_MRG_A) || (r_state == S_MRG_B) || (r_state == S_MRG_OUT), (r_a <= w_mid) && (r_b <= r_n), "merge pointer out of range")

endmodule

[rtl/core/half_sort_and_merge_sorter.sv]
// ----------------------------------------------------------------------------
// half_sort_and_merge_sorter
// loads one element per cycle while not busy, sorts both halves in the store, merges them
// after the final element each half is insertion sorted in place, one key
//   read and shift loop per element, then the merge is set up and each result
//   is picked from the heads of the two halves and registered at the output
// throughput: one element per cycle while loading, busy until the last result
// reset: synchronous, clears the batch and any pending result
// ----------------------------------------------------------------------------
module half_sort_and_merge_sorter
    import hsms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_valid,
    output t_out o_result
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    t_emit                 w_emit;
    logic                  r_valid;
    t_out                  r_result;

    hsms_ctrl #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .o_mem_we   (w_we),
        .o_mem_waddr(w_waddr),
        .o_mem_wdata(w_wdata),
        .o_mem_raddr(w_raddr),
        .i_mem_rdata(w_rdata),
        .o_emit     (w_emit)
    );

    hsms_ram #(
        .DEPTH(MAX_ELEMENTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= w_emit.data;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[dv/half_sort_and_merge_sorter_tb.sv]
// ----------------------------------------------------------------------------
// half_sort_and_merge_sorter_tb
// self-checking bench for the half sort and merge sorter: signed batches
// closed by a last flag or by a full store are sorted by a local predictor,
// and every result strobe is compared in order against the expected sequence
// ----------------------------------------------------------------------------
module half_sort_and_merge_sorter_tb;
    import hsms_pkg::*;

    localparam int MAX_N       = 64;
    localparam int ITEM_TARGET = 310;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 200;

    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = 32'sh8000_0000;

    typedef enum int {
        V_WIDE,
        V_TIES,
        V_EXTREME,
        V_MIXED
    } t_value_mode;

    class sort_scoreboard;
        logic signed [DATA_WIDTH-1:0] batch[$];
        t_out expected_q[$];
        int   errors;
        int   items_seen;
        int   batches_closed;
        int   full_batches;
        int   results_checked;

        task report(string msg);
            if (errors < 40)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_item(t_in item);
            logic signed [DATA_WIDTH-1:0] v[$];
            logic signed [DATA_WIDTH-1:0] t;
            t_out r;
            int   j;
            items_seen++;
            batch.push_back(item.value);
            if (!item.last && batch.size() < MAX_N)
                return;
            if (batch.size() == MAX_N)
                full_batches++;
            v = batch;
            for (int i = 1; i < v.size(); i++) begin
                t = v[i];
                j = i;
                while (j > 0 && v[j-1] > t) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = t;
            end
            foreach (v[k]) begin
                r.value_res = v[k];
                r.last_res  = (k == v.size() - 1);
                expected_q.push_back(r);
            end
            batch.delete();
            batches_closed++;
        endfunction

        task check_result(t_out got);
            t_out exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result value %0d last %0b",
                                 got.value_res, got.last_res));
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            if (got.value_res !== exp_r.value_res)
                report($sformatf("result %0d value %0d, expected %0d",
                                 results_checked, got.value_res, exp_r.value_res));
            if (got.last_res !== exp_r.last_res)
                report($sformatf("result %0d last %0b, expected %0b",
                                 results_checked, got.last_res, exp_r.last_res));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    sort_scoreboard sb = new();
    int  cycle_count = 0;
    int  items_sent  = 0;
    bit  gaps_on     = 1'b1;

    half_sort_and_merge_sorter #(
        .MAX_ELEMENTS(MAX_N)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_item(i_item);
            if (o_valid)
                sb.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] pick_value(t_value_mode mode);
        int sel;
        case (mode)
            V_WIDE: begin
                return $urandom;
            end
            V_TIES: begin
                return $signed($urandom_range(8)) - 4;
            end
            V_EXTREME: begin
                sel = $urandom_range(5);
                case (sel)
                    0: return MAX_VAL;
                    1: return MIN_VAL;
                    2: return MAX_VAL - 1;
                    3: return MIN_VAL + 1;
                    4: return -1;
                    default: return 0;
                endcase
            end
            default: begin
                sel = $urandom_range(9);
                if (sel < 6)
                    return $urandom;
                else if (sel < 9)
                    return pick_value(V_TIES);
                else
                    return pick_value(V_EXTREME);
            end
        endcase
    endfunction

    task automatic send_item(input logic signed [DATA_WIDTH-1:0] v, input logic l);
        t_in item;
        item.value = v;
        item.last  = l;
        if (gaps_on && $urandom_range(99) < 32) begin
            start <= 1'b0;
            i_item <= {$urandom, 1'($urandom)};
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_list(input logic signed [DATA_WIDTH-1:0] vals[$]);
        foreach (vals[k])
            send_item(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_batch(input int n, input bit mark_last, input t_value_mode mode);
        for (int k = 0; k < n; k++)
            send_item(pick_value(mode), mark_last && (k == n - 1));
    endtask

    initial begin
        logic signed [DATA_WIDTH-1:0] vals[$];
        int batch_no;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-element batches at both ends of the range
        vals = '{MAX_VAL};
        send_list(vals);
        vals = '{MIN_VAL};
        send_list(vals);
        // odd-sized batch with extremes
        vals = '{32'sd0, -32'sd1, MAX_VAL, MIN_VAL, 32'sd1};
        send_list(vals);
        // equal values across both halves
        vals = '{32'sd7, -32'sd3, 32'sd7, -32'sd3};
        send_list(vals);
        // descending, then ascending
        vals = '{32'sd50, 32'sd40, 32'sd30, 32'sd20, 32'sd10, -32'sd10};
        send_list(vals);
        vals = '{MIN_VAL, -32'sd2, 32'sd2, MAX_VAL};
        send_list(vals);

        batch_no = 0;
        while (items_sent < ITEM_TARGET) begin
            batch_no++;
            gaps_on = !(items_sent >= 120 && items_sent < 200);
            if (batch_no == 3)
                send_batch(MAX_N, 1'b0, V_MIXED);
            else if (batch_no == 9)
                send_batch(MAX_N, 1'b1, V_TIES);
            else
                send_batch($urandom_range(1, 12), 1'b1, V_MIXED);
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.batch.size() != 0)
            sb.report($sformatf("%0d items left in an open batch", sb.batch.size()));
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.expected_q.size()));

        $display("covered %0d items in %0d batches (%0d closed by a full store)",
                 sb.items_seen, sb.batches_closed, sb.full_batches);
        $display("checked %0d sorted results in %0d cycles, %0d mismatches",
                 sb.results_checked, cycle_count, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/hsms_pkg.sv
rtl/core/hsms_ram.sv
rtl/core/hsms_ctrl.sv
rtl/core/half_sort_and_merge_sorter.sv
dv/half_sort_and_merge_sorter_tb.sv
